// ----- hdl/tcce_pkg.sv -----
// Shared types and constants of the text console cursor engine.
package tcce_pkg;

    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int COLOR_W   = 4;
    localparam int GLYPH_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_PUT_CURSOR = 2'd0;
    localparam logic [1:0] OP_PUT_AT     = 2'd1;
    localparam logic [1:0] OP_READ       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 2'd1;

    localparam logic [GLYPH_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [GLYPH_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [GLYPH_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [COLOR_W-1:0] RST_DEF_FG = 4'd0;
    localparam logic [COLOR_W-1:0] RST_DEF_BG = 4'd15;

    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic [GLYPH_W-1:0] glyph;
    } t_cell;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [GLYPH_W-1:0] glyph;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
    } t_item;

    typedef struct packed {
        logic [GLYPH_W-1:0] read_glyph;
        logic [COLOR_W-1:0] read_fg;
        logic [COLOR_W-1:0] read_bg;
        logic [COL_W-1:0]   cursor_column;
        logic [ROW_W-1:0]   cursor_row;
        logic               scrolled;
    } t_result;

endpackage

// ----- hdl/tcce_cell_ram.sv -----
// Cell store: one write port, one registered read port.
module tcce_cell_ram
    import tcce_pkg::*;
#(
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_cell         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_cell         o_rdata
);

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/text_console_cursor_engine_unit.sv -----
// Top level of the text console cursor engine: sequencer, cursor and result register.
//
//  channel   direction  handshake             payload
//  item      in         start & !busy         i_item   (t_item)
//  result    out        o_done, one cycle     o_result (t_result)
//  config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// Put at cell, unused opcodes, out-of-range reads and a put at cursor that neither
// scrolls nor erases give the result in the cycle after the accept; other reads and
// backspaces read the store first, then capture or erase the cell. A newline or wrap
// on the last row scrolls, one store access a cycle through the single RAM port pair:
// S_COPY moves the rows below SCROLL_TOP up by one, S_BLANK blanks the bottom row.
// After reset a clearing pass fills every cell while busy is high; config writes are
// taken as ever. The receiver cannot stall: each result shows for one cycle.
module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int INFO_ROWS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_done,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    localparam int SCROLL_TOP  = (INFO_ROWS < ROWS) ? INFO_ROWS : ROWS - 1;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int AW          = $clog2(CELLS);
    localparam int CW          = $clog2(COLUMNS);
    localparam int RW          = $clog2(ROWS);
    localparam int INFO_CELLS  = ((INFO_ROWS < ROWS) ? INFO_ROWS : ROWS) * COLUMNS;
    localparam int COPY_FIRST  = SCROLL_TOP * COLUMNS;
    localparam int COPY_LAST   = (ROWS - 1) * COLUMNS - 1;
    localparam int BLANK_FIRST = (ROWS - 1) * COLUMNS;
    localparam bit HAS_COPY    = (SCROLL_TOP < ROWS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_ERASE = 3'd3;
    localparam logic [2:0] S_COPY  = 3'd4;
    localparam logic [2:0] S_BLANK = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_cur_col, n_cur_col;
    logic [RW-1:0]      r_cur_row, n_cur_row;
    logic               r_done, n_done;
    t_cell              r_rd_cell, n_rd_cell;
    logic               r_scrolled, n_scrolled;
    logic [COLOR_W-1:0] r_def_fg, r_def_bg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_cell         mem_wdata, mem_q;

    logic [AW-1:0] cur_addr, item_addr;
    logic          item_inside, col_wrap, row_last;
    t_cell         info_cell, body_cell, blank_cell, item_cell;

    tcce_cell_ram #(
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // Address arithmetic: one constant multiply and add each.
    assign cur_addr    = AW'(32'(r_cur_row) * COLUMNS + 32'(r_cur_col));
    assign item_addr   = AW'(32'(i_item.row) * COLUMNS + 32'(i_item.column));
    assign item_inside = (32'(i_item.column) < COLUMNS) && (32'(i_item.row) < ROWS);
    assign col_wrap    = (32'(r_cur_col) + 1) >= COLUMNS;
    assign row_last    = 32'(r_cur_row) >= ROWS - 1;

    // Power-up fill uses the reset defaults, info rows in inverted colors.
    assign info_cell  = '{bg: RST_DEF_FG, fg: RST_DEF_BG, glyph: CH_SPACE};
    assign body_cell  = '{bg: RST_DEF_BG, fg: RST_DEF_FG, glyph: CH_SPACE};
    assign blank_cell = '{bg: r_def_bg, fg: r_def_fg, glyph: CH_SPACE};
    assign item_cell  = '{bg: i_item.bg_color, fg: i_item.fg_color, glyph: i_item.glyph};

    always_comb begin
        logic v_newline;
        v_newline  = 1'b0;
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_cur_col  = r_cur_col;
        n_cur_row  = r_cur_row;
        n_done     = 1'b0;
        n_rd_cell  = r_rd_cell;
        n_scrolled = r_scrolled;
        mem_we     = 1'b0;
        mem_waddr  = r_ptr;
        mem_wdata  = blank_cell;
        mem_raddr  = r_ptr;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = (32'(r_ptr) < INFO_CELLS) ? info_cell : body_cell;
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_rd_cell  = '0;
                    n_scrolled = 1'b0;
                    unique case (i_item.opcode)
                        OP_PUT_CURSOR: begin
                            if (i_item.glyph == CH_NEWLINE) begin
                                v_newline = 1'b1;
                            end else if (i_item.glyph == CH_BACKSPACE) begin
                                if (r_cur_col != '0) begin
                                    // Step left, fetch the cell to keep its colors.
                                    n_cur_col = r_cur_col - 1'b1;
                                    n_ptr     = cur_addr - 1'b1;
                                    mem_raddr = cur_addr - 1'b1;
                                    n_state   = S_ERASE;
                                end else begin
                                    n_done = 1'b1;
                                end
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = item_cell;
                                if (col_wrap) begin
                                    v_newline = 1'b1;
                                end else begin
                                    n_cur_col = r_cur_col + 1'b1;
                                    n_done    = 1'b1;
                                end
                            end
                        end
                        OP_PUT_AT: begin
                            mem_we    = item_inside;
                            mem_waddr = item_addr;
                            mem_wdata = item_cell;
                            n_done    = 1'b1;
                        end
                        OP_READ: begin
                            if (item_inside) begin
                                mem_raddr = item_addr;
                                n_state   = S_READ;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                    if (v_newline) begin
                        n_cur_col = '0;
                        if (row_last) begin
                            // Scroll: copy rows up, then blank the bottom row.
                            if (HAS_COPY) begin
                                n_state   = S_COPY;
                                n_ptr     = AW'(COPY_FIRST);
                                mem_raddr = AW'(COPY_FIRST + COLUMNS);
                            end else begin
                                n_state = S_BLANK;
                                n_ptr   = AW'(BLANK_FIRST);
                            end
                        end else begin
                            n_cur_row = r_cur_row + 1'b1;
                            n_done    = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                n_rd_cell = mem_q;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_ERASE: begin
                mem_we    = 1'b1;
                mem_wdata = '{bg: mem_q.bg, fg: mem_q.fg, glyph: CH_SPACE};
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_COPY: begin
                // Write the cell fetched one row below, fetch the next one.
                mem_we    = 1'b1;
                mem_wdata = mem_q;
                if (r_ptr == AW'(COPY_LAST)) begin
                    n_state = S_BLANK;
                    n_ptr   = AW'(BLANK_FIRST);
                end else begin
                    n_ptr     = r_ptr + 1'b1;
                    mem_raddr = AW'(32'(r_ptr) + COLUMNS + 1);
                end
            end
            S_BLANK: begin
                mem_we    = 1'b1;
                mem_wdata = blank_cell;
                if (r_ptr == AW'(CELLS - 1)) begin
                    n_scrolled = 1'b1;
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_ptr      <= '0;
            r_cur_col  <= '0;
            r_cur_row  <= RW'(SCROLL_TOP);
            r_done     <= 1'b0;
            r_scrolled <= 1'b0;
            r_rd_cell  <= '0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_cur_col  <= n_cur_col;
            r_cur_row  <= n_cur_row;
            r_done     <= n_done;
            r_scrolled <= n_scrolled;
            r_rd_cell  <= n_rd_cell;
        end
    end

    // Scroll blank colors; the user must write them only while idle, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_fg <= RST_DEF_FG;
            r_def_bg <= RST_DEF_BG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEFAULT_FG: r_def_fg <= i_cfg_data;
                CFG_DEFAULT_BG: r_def_bg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign busy                   = (r_state != S_IDLE);
    assign o_done                 = r_done;
    assign o_result.read_glyph    = r_rd_cell.glyph;
    assign o_result.read_fg       = r_rd_cell.fg;
    assign o_result.read_bg       = r_rd_cell.bg;
    assign o_result.cursor_column = COL_W'(r_cur_col);
    assign o_result.cursor_row    = ROW_W'(r_cur_row);
    assign o_result.scrolled      = r_scrolled;

`ifndef NO_ASSERTIONS
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("store clearing pass not started after reset");

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while sequencer still busy");

    a_scroll_homes_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.scrolled |-> r_cur_col == '0)
        else $error("scroll left the cursor off column zero");

    a_cursor_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_row) >= SCROLL_TOP) && (32'(r_cur_row) < ROWS))
        else $error("cursor row left the scrolling area");

    a_put_at_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.opcode == OP_PUT_AT |=> o_done)
        else $error("put at cell did not finish in one cycle");
`endif

endmodule

// ----- bench/tcce_screen_checker.sv -----
// Screen-state checker for the text console cursor engine: tracks the item stream and compares every result.
module tcce_screen_checker
    import tcce_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int INFO_ROWS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_item                i_item,
    input  logic                 i_done,
    input  t_result              i_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);

    localparam int SCROLL_TOP = (INFO_ROWS < ROWS) ? INFO_ROWS : ROWS - 1;

    t_cell              screen [COLUMNS*ROWS];
    int                 cur_col;
    int                 cur_row;
    logic [COLOR_W-1:0] dflt_fg;
    logic [COLOR_W-1:0] dflt_bg;
    t_result            console_outputs [$];
    int                 mismatches = 0;

    assign o_errors = mismatches;

    function automatic void clear_screen();
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                if (r < INFO_ROWS) begin
                    screen[r*COLUMNS+c] = '{bg: dflt_fg, fg: dflt_bg, glyph: CH_SPACE};
                end else begin
                    screen[r*COLUMNS+c] = '{bg: dflt_bg, fg: dflt_fg, glyph: CH_SPACE};
                end
            end
        end
        cur_col = 0;
        cur_row = SCROLL_TOP;
    endfunction

    // Return the cursor to column 0; scroll when already on the last row.
    function automatic logic advance_line();
        cur_col = 0;
        if (cur_row >= ROWS - 1) begin
            for (int r = SCROLL_TOP; r + 1 < ROWS; r++) begin
                for (int c = 0; c < COLUMNS; c++) begin
                    screen[r*COLUMNS+c] = screen[(r+1)*COLUMNS+c];
                end
            end
            for (int c = 0; c < COLUMNS; c++) begin
                screen[(ROWS-1)*COLUMNS+c] = '{bg: dflt_bg, fg: dflt_fg, glyph: CH_SPACE};
            end
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    // Apply one item to the screen copy and return the result it must produce.
    function automatic t_result console_step(t_item it);
        t_result res;
        logic    in_range;
        int      idx;
        res      = '0;
        in_range = (int'(it.column) < COLUMNS) && (int'(it.row) < ROWS);
        idx      = int'(it.row) * COLUMNS + int'(it.column);
        case (it.opcode)
            OP_PUT_CURSOR: begin
                if (it.glyph == CH_NEWLINE) begin
                    res.scrolled = advance_line();
                end else if (it.glyph == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen[cur_row*COLUMNS+cur_col].glyph = CH_SPACE;
                    end
                end else begin
                    screen[cur_row*COLUMNS+cur_col] =
                        '{bg: it.bg_color, fg: it.fg_color, glyph: it.glyph};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        res.scrolled = advance_line();
                    end
                end
            end
            OP_PUT_AT: begin
                if (in_range) begin
                    screen[idx] = '{bg: it.bg_color, fg: it.fg_color, glyph: it.glyph};
                end
            end
            OP_READ: begin
                if (in_range) begin
                    res.read_glyph = screen[idx].glyph;
                    res.read_fg    = screen[idx].fg;
                    res.read_bg    = screen[idx].bg;
                end
            end
            default: ;
        endcase
        res.cursor_column = COL_W'(cur_col);
        res.cursor_row    = ROW_W'(cur_row);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            dflt_fg = RST_DEF_FG;
            dflt_bg = RST_DEF_BG;
            clear_screen();
            console_outputs.delete();
            o_pending <= 0;
        end else begin
            got = i_result;
            if (i_done) begin
                if (console_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: glyph %0d fg %0d bg %0d col %0d row %0d scr %0d",
                                 got.read_glyph, got.read_fg, got.read_bg,
                                 got.cursor_column, got.cursor_row, got.scrolled);
                    end
                end else begin
                    want = console_outputs.pop_front();
                    if (want.read_glyph !== got.read_glyph || want.read_fg !== got.read_fg ||
                        want.read_bg !== got.read_bg ||
                        want.cursor_column !== got.cursor_column ||
                        want.cursor_row !== got.cursor_row || want.scrolled !== got.scrolled) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: want glyph %0d fg %0d bg %0d col %0d row %0d scr %0d",
                                     want.read_glyph, want.read_fg, want.read_bg,
                                     want.cursor_column, want.cursor_row, want.scrolled);
                            $display("          got  glyph %0d fg %0d bg %0d col %0d row %0d scr %0d",
                                     got.read_glyph, got.read_fg, got.read_bg,
                                     got.cursor_column, got.cursor_row, got.scrolled);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEFAULT_FG: dflt_fg = i_cfg_data;
                    CFG_DEFAULT_BG: dflt_bg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                console_outputs.push_back(console_step(i_item));
            end
            o_pending <= console_outputs.size();
        end
    end

endmodule

// ----- bench/tb_text_console_cursor_engine_unit.sv -----
// Testbench top for the text console cursor engine: clock, reset, item and register stimulus, verdict.
module tb_text_console_cursor_engine_unit
    import tcce_pkg::*;
();

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int INFO_ROWS = 2;

    // Unused opcode: the block must leave everything alone and report the cursor.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Items per random phase; five phases give about 2000 items in all.
    localparam int PHASE_ITEMS = 400;

    // Worst case: every item a scroll plus sender gaps, for up to some 2500 items when
    // text lines run past a phase's count, plus the clearing pass after reset, taken
    // about four times over.
    localparam int LIMIT = 20_000_000;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_item                i_item     = '0;
    logic                 o_done;
    t_result              o_result;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [COLOR_W-1:0]   i_cfg_data = '0;

    int pending;
    int errors;
    int cycles   = 0;
    int idle_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    text_console_cursor_engine_unit #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .INFO_ROWS (INFO_ROWS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tcce_screen_checker #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .INFO_ROWS (INFO_ROWS)
    ) screen_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (i_item),
        .i_done     (o_done),
        .i_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // Watchdog: abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_item mk(logic [1:0] op, logic [GLYPH_W-1:0] g,
                                 logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg,
                                 logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        return '{opcode: op, glyph: g, fg_color: fg, bg_color: bg, column: col, row: row};
    endfunction

    // Any bit pattern in every field, unused opcode and out-of-range cells included.
    function automatic t_item noise_item();
        return mk(2'($urandom_range(3)), GLYPH_W'($urandom_range(255)),
                  COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)),
                  COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
    endfunction

    // A printable byte: anything but the two control codes.
    function automatic logic [GLYPH_W-1:0] text_glyph();
        logic [GLYPH_W-1:0] g;
        do begin
            g = GLYPH_W'($urandom_range(255));
        end while (g == CH_NEWLINE || g == CH_BACKSPACE);
        return g;
    endfunction

    // Put at cursor; the column and row fields are ignored, so fill them with noise.
    function automatic t_item cursor_item(logic [GLYPH_W-1:0] g);
        return mk(OP_PUT_CURSOR, g, COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)),
                  COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
    endfunction

    // Offer one item and hold it until the block takes it. Idle first at the
    // phase's rate, with junk on the item bus while start is low. Returns in
    // the time step of the accepting edge, start still high.
    task automatic offer(t_item it);
        while ($urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            i_item <= noise_item();
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and wait until the block is idle and every result has come.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register for a single cycle; only call while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One random phase, built from short well-formed sequences: lines of text,
    // write-then-read pairs, reads of the lower rows, newline runs, and noise.
    task automatic random_phase(int count);
        int                 n;
        int                 kind;
        int                 len;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [GLYPH_W-1:0] g;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                // a line of text; some run past the last column to force a wrap
                len = ($urandom_range(3) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
                for (int k = 0; k < len; k++) begin
                    g = ($urandom_range(19) == 0) ? CH_BACKSPACE : text_glyph();
                    offer(cursor_item(g));
                    n++;
                end
                if ($urandom_range(9) < 8) begin
                    offer(cursor_item(CH_NEWLINE));
                    n++;
                end
            end else if (kind < 65) begin
                col = COL_W'($urandom_range(COLUMNS - 1));
                row = ROW_W'($urandom_range(ROWS - 1));
                offer(mk(OP_PUT_AT, GLYPH_W'($urandom_range(255)), COLOR_W'($urandom_range(15)),
                         COLOR_W'($urandom_range(15)), col, row));
                offer(mk(OP_READ, GLYPH_W'($urandom_range(255)), COLOR_W'($urandom_range(15)),
                         COLOR_W'($urandom_range(15)), col, row));
                n += 2;
            end else if (kind < 80) begin
                // look at the scrolled area, where cleared rows carry the defaults
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    offer(mk(OP_READ, GLYPH_W'($urandom_range(255)),
                             COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)),
                             COL_W'($urandom_range(COLUMNS - 1)),
                             ROW_W'($urandom_range(INFO_ROWS, ROWS - 1))));
                    n++;
                end
            end else if (kind < 90) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    offer(cursor_item(CH_NEWLINE));
                    n++;
                end
            end else begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) begin
                    offer(noise_item());
                    n++;
                end
            end
        end
    endtask

    initial begin
        // Hold reset, then wait out the clearing pass.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Directed: corners, out-of-range cells, control bytes stored as data,
        // unused opcode, backspace at column 0, and a few cursor writes.
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd0, 5'd0));
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd79, 5'd24));
        offer(mk(OP_READ, 8'hFF, 4'd15, 4'd15, 7'd127, 5'd31));
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd80, 5'd0));
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd0, 5'd25));
        offer(mk(OP_PUT_AT, 8'hFF, 4'd15, 4'd15, 7'd79, 5'd24));
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd79, 5'd24));
        offer(mk(OP_PUT_AT, 8'h00, 4'd0, 4'd0, 7'd0, 5'd0));
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd0, 5'd0));
        offer(mk(OP_PUT_AT, CH_NEWLINE, 4'd3, 4'd12, 7'd5, 5'd1));
        offer(mk(OP_PUT_AT, CH_BACKSPACE, 4'd12, 4'd3, 7'd6, 5'd2));
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd5, 5'd1));
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd6, 5'd2));
        offer(mk(OP_PUT_AT, 8'h41, 4'd1, 4'd2, 7'd127, 5'd31));
        offer(mk(OP_UNUSED, 8'hFF, 4'd15, 4'd15, 7'd127, 5'd31));
        offer(mk(OP_PUT_CURSOR, CH_BACKSPACE, 4'd15, 4'd15, 7'd0, 5'd0));
        offer(mk(OP_PUT_CURSOR, 8'h00, 4'd0, 4'd0, 7'd0, 5'd0));
        offer(mk(OP_PUT_CURSOR, 8'hFF, 4'd15, 4'd15, 7'd127, 5'd31));
        offer(mk(OP_PUT_CURSOR, CH_SPACE, 4'd5, 4'd10, 7'd0, 5'd0));
        offer(mk(OP_PUT_CURSOR, CH_BACKSPACE, 4'd0, 4'd0, 7'd0, 5'd0));
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd1, 5'd2));
        offer(mk(OP_PUT_CURSOR, CH_NEWLINE, 4'd0, 4'd0, 7'd0, 5'd0));
        offer(mk(OP_READ, 8'h00, 4'd0, 4'd0, 7'd0, 5'd2));
        settle();

        // Phase 0: reset defaults, no idling.
        idle_pct = 0;
        random_phase(PHASE_ITEMS);
        settle();

        // Phase 1: swapped extremes, sparse sender.
        write_reg(CFG_DEFAULT_FG, 4'd15);
        write_reg(CFG_DEFAULT_BG, 4'd0);
        idle_pct = 72;
        random_phase(PHASE_ITEMS);
        settle();

        // Phase 2: both low, light idling.
        write_reg(CFG_DEFAULT_FG, 4'd0);
        write_reg(CFG_DEFAULT_BG, 4'd0);
        idle_pct = 22;
        random_phase(PHASE_ITEMS);
        settle();

        // Phase 3: both high, sparse sender.
        write_reg(CFG_DEFAULT_FG, 4'd15);
        write_reg(CFG_DEFAULT_BG, 4'd15);
        idle_pct = 72;
        random_phase(PHASE_ITEMS);
        settle();

        // Phase 4: random defaults, back-to-back items.
        write_reg(CFG_DEFAULT_FG, COLOR_W'($urandom_range(15)));
        write_reg(CFG_DEFAULT_BG, COLOR_W'($urandom_range(15)));
        idle_pct = 0;
        random_phase(PHASE_ITEMS);
        settle();

        // Let any straggling strobe show up before the verdict.
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
